// ===== rtl/bbs_pkg.sv =====
// Shared constants and codes for the bitmap block store.
package bbs_pkg;

  // Default geometry of the store
  localparam int BBS_NUM_BLOCKS  = 255;
  localparam int BBS_BLOCK_BYTES = 256;

  // Field widths fixed by the word format
  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;

  // Padded word widths on the stream ports
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE    = 3'd4;

endpackage

// ===== rtl/bitmap_block_store_unit.sv =====
// Bitmap block store: allocation map, block byte memory and operation sequencer.
//
//   Channel | Direction | tuser     | tdata fields, lowest bit first
//   in_     | slave     | kind[2:0] | block_num[7:0] byte_offset[15:8] write_data[23:16]
//   out_    | master    | -         | status[2:0] result_block[10:3] read_data[18:11]
//           |           |           | used_count[26:19] free_count[34:27]
//
// One word is taken at a time; in_tready is high only while the sequencer idles.
// Allocate walks the map one block per cycle, from block 0 up to the first free one
// (at most min(NUM_BLOCKS,256) blocks). Read and write subtract BLOCK_BYTES from the
// offset until it is below it, form the address, then access memory; others go to DONE.
// Reset clears the map and the used count; block bytes stay undefined until written.
// A finished result waits in the output register; a new word is accepted meanwhile,
// and only its completion waits for the output register to empty.
module bitmap_block_store_unit
  import bbs_pkg::*;
#(
  parameter int NUM_BLOCKS  = BBS_NUM_BLOCKS,
  parameter int BLOCK_BYTES = BBS_BLOCK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  // block_num, byte_offset, write_data
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, result_block, read_data, used_count, free_count; zero padded
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Only ids that fit in the id field can be mapped
  localparam int MAP_N     = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int IDX_W     = $clog2(MAP_N);
  localparam int MEM_DEPTH = MAP_N * BLOCK_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CMP_W     = ($clog2(BLOCK_BYTES + 1) > BYTE_W + 1) ?
                             $clog2(BLOCK_BYTES + 1) : BYTE_W + 1;
  localparam int USED_W    = $clog2(MAP_N + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAP_N - 1);
  localparam logic [ID_W:0]     MAP_N_ID  = (ID_W + 1)'(MAP_N);
  localparam logic [CMP_W-1:0]  BB_CMP    = CMP_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] BB_ADDR   = ADDR_W'(BLOCK_BYTES);
  localparam logic [COUNT_W-1:0] NB_LOW   = COUNT_W'(NUM_BLOCKS);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_MEM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [KIND_W-1:0]     kind_r;
  logic [ID_W-1:0]       id_r;
  logic [BYTE_W-1:0]     acc_r;
  logic [BYTE_W-1:0]     wdata_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  found_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [BYTE_W-1:0]     rd_data_r;
  logic [MAP_N-1:0]      map_r, map_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [BYTE_W-1:0]     mem [MEM_DEPTH];

  logic                  in_fire;
  logic                  out_free;
  logic [KIND_W-1:0]     in_kind;
  logic [ID_W-1:0]       in_id;
  logic                  in_id_ok;
  logic                  id_ok;
  logic                  id_mapped;
  logic [CMP_W-1:0]      acc_ext;
  logic                  acc_ge;
  logic [CMP_W-1:0]      acc_diff;
  logic [STATUS_W-1:0]   res_status;
  logic [ID_W-1:0]       res_block;
  logic [BYTE_W-1:0]     res_rdata;
  logic [COUNT_W-1:0]    res_used;
  logic [COUNT_W-1:0]    res_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_kind  = in_tuser;
  assign in_id    = in_tdata[7:0];
  assign in_id_ok = ({1'b0, in_id} < MAP_N_ID);
  assign id_ok    = ({1'b0, id_r} < MAP_N_ID);
  assign id_mapped = id_ok && map_r[id_r[IDX_W-1:0]];

  // Shared compare and subtract for the offset wrap
  assign acc_ext  = CMP_W'(acc_r);
  assign acc_ge   = (acc_ext >= BB_CMP);
  assign acc_diff = acc_ext - BB_CMP;

  // Sequence the operation
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_ALLOC) begin
            state_nxt = S_SCAN;
          end else if ((in_kind == KIND_READ || in_kind == KIND_WRITE) && in_id_ok &&
                       map_r[in_id[IDX_W-1:0]]) begin
            state_nxt = S_WRAP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (!map_r[idx_r] || idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end
      end
      S_WRAP: begin
        if (!acc_ge) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR:  state_nxt = S_MEM;
      S_MEM:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Form the result and the map update of the finished operation
  always_comb begin
    res_status = ST_OK;
    res_block  = id_r;
    res_rdata  = '0;
    map_nxt    = map_r;
    used_nxt   = used_r;
    case (kind_r) inside
      KIND_ALLOC: begin
        if (found_r) begin
          res_block      = ID_W'(idx_r);
          map_nxt[idx_r] = 1'b1;
          used_nxt       = used_r + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_REQUEST, KIND_RELEASE, KIND_READ, KIND_WRITE: begin
        if (!id_ok) begin
          res_status = ST_INVALID;
        end else if (kind_r == KIND_REQUEST) begin
          if (id_mapped) begin
            res_status = ST_TAKEN;
          end else begin
            map_nxt[id_r[IDX_W-1:0]] = 1'b1;
            used_nxt                 = used_r + 1'b1;
          end
        end else if (kind_r == KIND_RELEASE) begin
          if (id_mapped) begin
            map_nxt[id_r[IDX_W-1:0]] = 1'b0;
            used_nxt                 = used_r - 1'b1;
          end
        end else if (!id_mapped) begin
          res_status = ST_FREE;
        end else if (kind_r == KIND_READ) begin
          res_rdata = rd_data_r;
        end
      end
      default: ;
    endcase
    res_used = COUNT_W'(used_nxt);
    res_free = NB_LOW - COUNT_W'(used_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        map_r       <= map_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operands, scan index, offset wrap and address
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_kind;
      id_r    <= in_id;
      acc_r   <= in_tdata[15:8];
      wdata_r <= in_tdata[23:16];
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (!map_r[idx_r]) begin
        found_r <= 1'b1;
      end else if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
    end
    if (state_r == S_WRAP && acc_ge) begin
      acc_r <= acc_diff[BYTE_W-1:0];
    end
    if (state_r == S_ADDR) begin
      addr_r <= ADDR_W'(id_r) * BB_ADDR + ADDR_W'(acc_r);
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {res_free, res_used, res_rdata, res_block, res_status};
    end
  end

  // Block byte memory: at most one access per operation, for read and write
  always_ff @(posedge clk) begin
    if (state_r == S_MEM) begin
      if (kind_r == KIND_WRITE) begin
        mem[addr_r] <= wdata_r;
      end
      rd_data_r <= mem[addr_r];
    end
  end

endmodule
